// ===== rtl/mbr_pkg.sv =====
package mbr_pkg;

    localparam int RESPONSE_BYTES = 9;
    localparam int STORE_DEPTH    = 7;
    localparam int STORE_IDX_W    = $clog2(STORE_DEPTH);
    localparam int CNT_W          = 4;
    localparam int FRAME_IDX_W    = 3;
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = 16;

    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [7:0]  FUNC_READ      = 8'h03;
    localparam logic [7:0]  FUNC_READ_EXC  = 8'h83;
    localparam logic [15:0] REG_COUNT      = 16'h0002;
    localparam logic [7:0]  BYTE_COUNT     = 8'h04;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd2000;
    localparam logic [15:0] TICKS_MAX      = 16'hFFFF;

    localparam logic [FRAME_IDX_W-1:0] FRAME_SLAVE   = 3'd0;
    localparam logic [FRAME_IDX_W-1:0] FRAME_FUNC    = 3'd1;
    localparam logic [FRAME_IDX_W-1:0] FRAME_ADDR_HI = 3'd2;
    localparam logic [FRAME_IDX_W-1:0] FRAME_ADDR_LO = 3'd3;
    localparam logic [FRAME_IDX_W-1:0] FRAME_CNT_HI  = 3'd4;
    localparam logic [FRAME_IDX_W-1:0] FRAME_CNT_LO  = 3'd5;
    localparam logic [FRAME_IDX_W-1:0] FRAME_CRC_LO  = 3'd6;
    localparam logic [FRAME_IDX_W-1:0] FRAME_CRC_HI  = 3'd7;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_RX_BYTE = 2'd1,
        CMD_TICK    = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_TIMEOUT        = 3'd1,
        ST_SLAVE_MISMATCH = 3'd2,
        ST_EXCEPTION      = 3'd3,
        ST_UNKNOWN_FUNC   = 3'd4,
        ST_BAD_COUNT      = 3'd5,
        ST_NOT_CONNECTED  = 3'd6
    } status_t;

    typedef enum logic {
        KIND_TX     = 1'b0,
        KIND_REPORT = 1'b1
    } kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LINK_ENABLED     = 1'b0,
        CFG_RESPONSE_TIMEOUT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  target_id;
        logic [15:0] reg_addr;
        logic [7:0]  rx_byte;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  tx_byte;
        logic        last;
        status_t     status;
        logic [7:0]  exception_code;
        logic [15:0] temperature_tenths;
        logic [15:0] humidity_tenths;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/mbr_if.sv =====
interface mbr_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  target_id;
    logic [15:0] reg_addr;
    logic [7:0]  rx_byte;

    modport source (output valid, output command, output target_id, output reg_addr,
                    output rx_byte, input ready);
    modport sink   (input valid, input command, input target_id, input reg_addr,
                    input rx_byte, output ready);
endinterface

interface mbr_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [2:0]  status;
    logic [7:0]  exception_code;
    logic [15:0] temperature_tenths;
    logic [15:0] humidity_tenths;

    modport source (output valid, output kind, output tx_byte, output last, output status,
                    output exception_code, output temperature_tenths,
                    output humidity_tenths, input ready);
    modport sink   (input valid, input kind, input tx_byte, input last, input status,
                    input exception_code, input temperature_tenths,
                    input humidity_tenths, output ready);
endinterface

// ===== rtl/mbr_in_reg.sv =====
module mbr_in_reg (
    input  logic          clk,
    input  logic          rst_n,
    mbr_item_if.sink      item,
    output mbr_pkg::item_t data,
    output logic          valid,
    input  logic          take
);
    import mbr_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t data_reg;

    assign item.ready = !valid_reg || take;
    assign valid      = valid_reg;
    assign data       = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (item.valid && item.ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            data_reg.command   <= item.command;
            data_reg.target_id <= item.target_id;
            data_reg.reg_addr  <= item.reg_addr;
            data_reg.rx_byte   <= item.rx_byte;
        end
    end
endmodule

// ===== rtl/mbr_engine.sv =====
module mbr_engine (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mbr_pkg::item_t                     item,
    input  logic                               item_valid,
    output logic                               item_take,
    output mbr_pkg::result_t                   res,
    output logic                               res_load,
    input  logic                               out_free,
    input  logic                               cfg_we,
    input  logic [mbr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mbr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mbr_pkg::*;

    logic                   link_reg, link_next;
    logic [15:0]            timeout_reg, timeout_next;
    logic                   pending_reg, pending_next;
    logic [7:0]             expected_reg, expected_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [15:0]            ticks_reg, ticks_next;
    logic                   busy_reg, busy_next;
    logic [FRAME_IDX_W-1:0] idx_reg, idx_next;
    logic [15:0]            addr_reg, addr_next;
    logic [15:0]            crc_reg, crc_next;
    logic [7:0]             store_reg [STORE_DEPTH];
    logic [7:0]             store_next [STORE_DEPTH];

    logic [7:0]             frame_byte;
    logic [CNT_W-1:0]       count_inc;
    logic [15:0]            ticks_inc;
    result_t                report;

    always_comb
    begin
        case (idx_reg)
            FRAME_FUNC:    frame_byte = FUNC_READ;
            FRAME_ADDR_HI: frame_byte = addr_reg[15:8];
            FRAME_ADDR_LO: frame_byte = addr_reg[7:0];
            FRAME_CNT_HI:  frame_byte = REG_COUNT[15:8];
            FRAME_CNT_LO:  frame_byte = REG_COUNT[7:0];
            FRAME_CRC_LO:  frame_byte = crc_reg[7:0];
            FRAME_CRC_HI:  frame_byte = crc_reg[15:8];
            default:       frame_byte = expected_reg;
        endcase
    end

    always_comb
    begin
        report      = '0;
        report.kind = KIND_REPORT;
        if (store_reg[0] != expected_reg)
        begin
            report.status = ST_SLAVE_MISMATCH;
        end
        else if (store_reg[1] == FUNC_READ_EXC)
        begin
            report.status         = ST_EXCEPTION;
            report.exception_code = store_reg[2];
        end
        else if (store_reg[1] != FUNC_READ)
        begin
            report.status = ST_UNKNOWN_FUNC;
        end
        else if (store_reg[2] != BYTE_COUNT)
        begin
            report.status = ST_BAD_COUNT;
        end
        else
        begin
            report.status             = ST_OK;
            report.temperature_tenths = {store_reg[3], store_reg[4]};
            report.humidity_tenths    = {store_reg[5], store_reg[6]};
        end
    end

    assign count_inc = count_reg + CNT_W'(1);
    assign ticks_inc = (ticks_reg != TICKS_MAX) ? ticks_reg + 16'd1 : ticks_reg;
    assign item_take = item_valid && !busy_reg && out_free;

    always_comb
    begin
        link_next     = link_reg;
        timeout_next  = timeout_reg;
        pending_next  = pending_reg;
        expected_next = expected_reg;
        count_next    = count_reg;
        ticks_next    = ticks_reg;
        busy_next     = busy_reg;
        idx_next      = idx_reg;
        addr_next     = addr_reg;
        crc_next      = crc_reg;
        store_next    = store_reg;
        res           = '0;
        res_load      = 1'b0;

        if (busy_reg && out_free)
        begin
            res.kind    = KIND_TX;
            res.tx_byte = frame_byte;
            res.last    = (idx_reg == FRAME_CRC_HI);
            res_load    = 1'b1;
            idx_next    = idx_reg + FRAME_IDX_W'(1);
            if (idx_reg < FRAME_CRC_LO)
            begin
                crc_next = crc_byte(crc_reg, frame_byte);
            end
            if (idx_reg == FRAME_CRC_HI)
            begin
                busy_next = 1'b0;
            end
        end
        else if (item_take)
        begin
            case (cmd_t'(item.command))
                CMD_START:
                begin
                    if (!link_reg)
                    begin
                        res.kind   = KIND_REPORT;
                        res.status = ST_NOT_CONNECTED;
                        res_load   = 1'b1;
                    end
                    else
                    begin
                        res.kind      = KIND_TX;
                        res.tx_byte   = item.target_id;
                        res_load      = 1'b1;
                        crc_next      = crc_byte(CRC_INIT, item.target_id);
                        idx_next      = FRAME_FUNC;
                        busy_next     = 1'b1;
                        addr_next     = item.reg_addr;
                        pending_next  = 1'b1;
                        expected_next = item.target_id;
                        count_next    = '0;
                        ticks_next    = '0;
                    end
                end
                CMD_RX_BYTE:
                begin
                    if (pending_reg)
                    begin
                        if (count_reg < CNT_W'(STORE_DEPTH))
                        begin
                            store_next[count_reg[STORE_IDX_W-1:0]] = item.rx_byte;
                        end
                        count_next = count_inc;
                        if (count_inc == CNT_W'(RESPONSE_BYTES))
                        begin
                            pending_next = 1'b0;
                            count_next   = '0;
                            res          = report;
                            res_load     = 1'b1;
                        end
                    end
                end
                CMD_TICK:
                begin
                    if (pending_reg)
                    begin
                        ticks_next = ticks_inc;
                        if (ticks_inc >= timeout_reg)
                        begin
                            pending_next = 1'b0;
                            count_next   = '0;
                            res.kind     = KIND_REPORT;
                            res.status   = ST_TIMEOUT;
                            res_load     = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_LINK_ENABLED:
                begin
                    link_next = cfg_data[0];
                    if (!cfg_data[0])
                    begin
                        pending_next = 1'b0;
                    end
                end
                CFG_RESPONSE_TIMEOUT:
                begin
                    timeout_next = cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg     <= 1'b0;
            timeout_reg  <= TIMEOUT_RESET;
            pending_reg  <= 1'b0;
            expected_reg <= '0;
            count_reg    <= '0;
            ticks_reg    <= '0;
            busy_reg     <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            link_reg     <= link_next;
            timeout_reg  <= timeout_next;
            pending_reg  <= pending_next;
            expected_reg <= expected_next;
            count_reg    <= count_next;
            ticks_reg    <= ticks_next;
            busy_reg     <= busy_next;
            idx_reg      <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        crc_reg   <= crc_next;
        store_reg <= store_next;
    end
endmodule

// ===== rtl/mbr_out_reg.sv =====
module mbr_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  mbr_pkg::result_t data,
    input  logic             load,
    output logic             free,
    mbr_result_if.source     result
);
    import mbr_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign free                      = !valid_reg || result.ready;
    assign result.valid              = valid_reg;
    assign result.kind               = data_reg.kind;
    assign result.tx_byte            = data_reg.tx_byte;
    assign result.last               = data_reg.last;
    assign result.status             = data_reg.status;
    assign result.exception_code     = data_reg.exception_code;
    assign result.temperature_tenths = data_reg.temperature_tenths;
    assign result.humidity_tenths    = data_reg.humidity_tenths;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data;
        end
    end
endmodule

// ===== rtl/modbus_rtu_two_register_reader.sv =====
// Each item is captured in the input register, and its first result is registered in the output register.
// Byte and tick items are handled when taken; a start item holds the frame sequencer for its
// eight request bytes, one per cycle while the output is free, the CRC advancing a byte a cycle.
// Reset (rst_n, asynchronous, active low) closes the link, sets the timeout to 2000 ticks,
// drops any pending exchange and empties both registers; the response store is not cleared.
module modbus_rtu_two_register_reader (
    input  logic                            clk,
    input  logic                            rst_n,
    mbr_item_if.sink                        item,
    mbr_result_if.source                    result,
    input  logic                            cfg_we,
    input  logic [mbr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mbr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mbr_pkg::*;

    item_t   item_data;
    logic    item_valid;
    logic    item_take;
    result_t res;
    logic    res_load;
    logic    out_free;

    mbr_in_reg u_in_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .data  (item_data),
        .valid (item_valid),
        .take  (item_take)
    );

    mbr_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_data),
        .item_valid (item_valid),
        .item_take  (item_take),
        .res        (res),
        .res_load   (res_load),
        .out_free   (out_free),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    mbr_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .data   (res),
        .load   (res_load),
        .free   (out_free),
        .result (result)
    );
endmodule

// ===== tb/tb_modbus_rtu_two_register_reader.sv =====
module tb_modbus_rtu_two_register_reader;
    import mbr_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 1000000;
    localparam int         DRAIN_GAP   = 16;
    localparam int         PHASE_ITEMS = 52;
    localparam int         SHOW_LIMIT  = 20;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    mbr_item_if   item_ch();
    mbr_result_if result_ch();

    modbus_rtu_two_register_reader DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic        link_on;
    logic [15:0] timeout_ticks;
    logic        awaiting;
    logic [7:0]  want_slave;
    logic [3:0]  rx_count;
    logic [7:0]  rx_store [STORE_DEPTH];
    logic [15:0] ticks_seen;

    result_t results_due [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_left      = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int errors         = 0;
    int cycle_count    = 0;
    int status_count [8];

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [15:0] request_crc(input logic [47:0] head);
        logic [15:0] acc;
        acc = CRC_INIT;
        for (int i = 0; i < 6; i++)
        begin
            acc = acc ^ {8'h00, head[47 - 8*i -: 8]};
            for (int b = 0; b < 8; b++)
            begin
                acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
            end
        end
        return acc;
    endfunction

    function automatic result_t report_of(status_t st, logic [7:0] exc,
                                          logic [15:0] t, logic [15:0] h);
        result_t r;
        r = '0;
        r.kind               = KIND_REPORT;
        r.status             = st;
        r.exception_code     = exc;
        r.temperature_tenths = t;
        r.humidity_tenths    = h;
        return r;
    endfunction

    function automatic void reader_step(logic [1:0] cmd, logic [7:0] sid,
                                        logic [15:0] addr, logic [7:0] rxb);
        logic [47:0] head;
        logic [15:0] crc;
        logic [63:0] frame;
        result_t     r;
        case (cmd)
            CMD_START:
            begin
                if (!link_on)
                begin
                    r = report_of(ST_NOT_CONNECTED, 8'h00, 16'h0000, 16'h0000);
                    results_due = {results_due, r};
                end
                else
                begin
                    head  = {sid, FUNC_READ, addr, REG_COUNT};
                    crc   = request_crc(head);
                    frame = {head, crc[7:0], crc[15:8]};
                    for (int i = 0; i < 8; i++)
                    begin
                        r         = '0;
                        r.kind    = KIND_TX;
                        r.tx_byte = frame[63 - 8*i -: 8];
                        r.last    = (i == 7);
                        results_due = {results_due, r};
                    end
                    awaiting   = 1'b1;
                    want_slave = sid;
                    rx_count   = '0;
                    ticks_seen = '0;
                end
            end
            CMD_RX_BYTE:
            begin
                if (awaiting)
                begin
                    if (rx_count < CNT_W'(STORE_DEPTH))
                    begin
                        rx_store[rx_count[STORE_IDX_W-1:0]] = rxb;
                    end
                    rx_count = rx_count + 4'd1;
                    if (rx_count == CNT_W'(RESPONSE_BYTES))
                    begin
                        awaiting = 1'b0;
                        rx_count = '0;
                        if (rx_store[0] != want_slave)
                        begin
                            r = report_of(ST_SLAVE_MISMATCH, 8'h00, 16'h0000, 16'h0000);
                        end
                        else if (rx_store[1] == FUNC_READ_EXC)
                        begin
                            r = report_of(ST_EXCEPTION, rx_store[2], 16'h0000, 16'h0000);
                        end
                        else if (rx_store[1] != FUNC_READ)
                        begin
                            r = report_of(ST_UNKNOWN_FUNC, 8'h00, 16'h0000, 16'h0000);
                        end
                        else if (rx_store[2] != BYTE_COUNT)
                        begin
                            r = report_of(ST_BAD_COUNT, 8'h00, 16'h0000, 16'h0000);
                        end
                        else
                        begin
                            r = report_of(ST_OK, 8'h00, {rx_store[3], rx_store[4]},
                                          {rx_store[5], rx_store[6]});
                        end
                        results_due = {results_due, r};
                    end
                end
            end
            CMD_TICK:
            begin
                if (awaiting)
                begin
                    if (ticks_seen != TICKS_MAX)
                    begin
                        ticks_seen = ticks_seen + 16'd1;
                    end
                    if (ticks_seen >= timeout_ticks)
                    begin
                        awaiting = 1'b0;
                        rx_count = '0;
                        r = report_of(ST_TIMEOUT, 8'h00, 16'h0000, 16'h0000);
                        results_due = {results_due, r};
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic send_item(logic [1:0] cmd, logic [7:0] sid, logic [15:0] addr,
                             logic [7:0] rxb);
        while ($urandom_range(99) < src_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.command   <= cmd;
        item_ch.target_id <= sid;
        item_ch.reg_addr  <= addr;
        item_ch.rx_byte   <= rxb;
        @(posedge clk);
        while (!item_ch.ready)
        begin
            @(posedge clk);
        end
        reader_step(cmd, sid, addr, rxb);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, 8'($urandom), 16'($urandom), 8'($urandom));
    endtask

    task automatic send_start(logic [7:0] sid, logic [15:0] addr);
        send_item(CMD_START, sid, addr, 8'($urandom));
    endtask

    task automatic send_response(logic [7:0] sid, logic [7:0] func, logic [7:0] third,
                                 logic [15:0] t, logic [15:0] h, int nbytes, int tick_pct);
        logic [71:0] bytes;
        bytes = {sid, func, third, t, h, 16'($urandom)};
        for (int i = 0; i < nbytes; i++)
        begin
            if ($urandom_range(99) < tick_pct)
            begin
                send_tick();
            end
            send_item(CMD_RX_BYTE, 8'($urandom), 16'($urandom), bytes[71 - 8*i -: 8]);
        end
    endtask

    task automatic write_cfg(cfg_index_t idx, logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_LINK_ENABLED:
            begin
                link_on = data[0];
                if (!link_on)
                begin
                    awaiting = 1'b0;
                end
            end
            CFG_RESPONSE_TIMEOUT:
            begin
                timeout_ticks = data;
            end
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (results_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_GAP) @(negedge clk);
    endtask

    task automatic set_idling(int src, int sink);
        src_idle_pct   = src;
        sink_stall_pct = sink;
    endtask

    task automatic test_link_down();
        send_start(8'hFF, 16'hFFFF);
        send_item(CMD_RX_BYTE, 8'h00, 16'h0000, 8'hFF);
        send_item(CMD_TICK, 8'hFF, 16'hFFFF, 8'h00);
        send_item(CMD_UNUSED, 8'hFF, 16'hFFFF, 8'h00);
        wait_drained();
        write_cfg(CFG_LINK_ENABLED, 16'h0001);
    endtask

    task automatic test_good_reads();
        send_start(8'h00, 16'h0000);
        send_response(8'h00, FUNC_READ, BYTE_COUNT, 16'hFFFF, 16'h0000, RESPONSE_BYTES, 0);
        send_start(8'hFF, 16'hFFFF);
        send_response(8'hFF, FUNC_READ, BYTE_COUNT, 16'h0000, 16'hFFFF, RESPONSE_BYTES, 0);
        wait_drained();
    endtask

    task automatic test_bad_responses();
        send_start(8'h5A, 16'h1234);
        send_response(8'h5B, FUNC_READ_EXC, 8'h02, 16'h0000, 16'h0000, RESPONSE_BYTES, 0);
        send_start(8'h5A, 16'h1234);
        send_response(8'h5A, FUNC_READ_EXC, 8'hFF, 16'h0102, 16'h0304, RESPONSE_BYTES, 0);
        send_start(8'h5A, 16'h1234);
        send_response(8'h5A, 8'h04, BYTE_COUNT, 16'h0102, 16'h0304, RESPONSE_BYTES, 0);
        send_start(8'h5A, 16'h1234);
        send_response(8'h5A, FUNC_READ, 8'h03, 16'h0102, 16'h0304, RESPONSE_BYTES, 0);
        wait_drained();
    endtask

    task automatic test_restart_and_abort();
        send_start(8'h11, 16'h0100);
        send_response(8'h11, FUNC_READ, BYTE_COUNT, 16'h00F0, 16'h0F00, 4, 0);
        send_start(8'h22, 16'h8001);
        send_response(8'h22, FUNC_READ, BYTE_COUNT, 16'h00F0, 16'h0F00, RESPONSE_BYTES, 0);
        send_start(8'h33, 16'h7FFE);
        wait_drained();
        write_cfg(CFG_LINK_ENABLED, 16'h0000);
        write_cfg(CFG_LINK_ENABLED, 16'h0001);
        send_response(8'h33, FUNC_READ, BYTE_COUNT, 16'h1111, 16'h2222, RESPONSE_BYTES, 0);
        send_tick();
        send_start(8'h44, 16'h0044);
        send_item(CMD_UNUSED, 8'h44, 16'h0044, 8'h44);
        send_response(8'h44, FUNC_READ, BYTE_COUNT, 16'h1234, 16'h5678, RESPONSE_BYTES, 0);
        wait_drained();
    endtask

    task automatic test_timeouts();
        write_cfg(CFG_RESPONSE_TIMEOUT, 16'd0);
        send_start(8'h80, 16'h0000);
        send_tick();
        wait_drained();
        write_cfg(CFG_RESPONSE_TIMEOUT, 16'd1);
        send_start(8'h81, 16'h0001);
        send_tick();
        send_item(CMD_RX_BYTE, 8'h00, 16'h0000, 8'h81);
        wait_drained();
        write_cfg(CFG_RESPONSE_TIMEOUT, 16'd3);
        send_start(8'h82, 16'h0002);
        send_response(8'h82, FUNC_READ, BYTE_COUNT, 16'h0000, 16'h0000, 4, 0);
        repeat (3) send_tick();
        send_response(8'h82, FUNC_READ, BYTE_COUNT, 16'h0000, 16'h0000, 5, 0);
        wait_drained();
        write_cfg(CFG_RESPONSE_TIMEOUT, 16'hFFFF);
        send_start(8'h83, 16'h0003);
        repeat (20) send_tick();
        send_response(8'h83, FUNC_READ, BYTE_COUNT, 16'h0103, 16'h0203, RESPONSE_BYTES, 0);
        wait_drained();
        write_cfg(CFG_RESPONSE_TIMEOUT, TIMEOUT_RESET);
    endtask

    task automatic random_exchange();
        int          pick;
        logic [7:0]  sid;
        logic [15:0] t;
        logic [15:0] h;
        pick = $urandom_range(99);
        sid  = 8'($urandom);
        t    = 16'($urandom);
        h    = 16'($urandom);
        if (pick < 10)
        begin
            send_item(2'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
        end
        else
        begin
            send_start(sid, 16'($urandom));
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                send_response(sid, FUNC_READ, BYTE_COUNT, t, h, RESPONSE_BYTES, 10);
            end
            else if (pick < 65)
            begin
                send_response(sid ^ 8'($urandom_range(1, 255)), FUNC_READ, BYTE_COUNT, t, h,
                              RESPONSE_BYTES, 10);
            end
            else if (pick < 73)
            begin
                send_response(sid, FUNC_READ_EXC, 8'($urandom), t, h, RESPONSE_BYTES, 10);
            end
            else if (pick < 80)
            begin
                send_response(sid, 8'($urandom), BYTE_COUNT, t, h, RESPONSE_BYTES, 10);
            end
            else if (pick < 87)
            begin
                send_response(sid, FUNC_READ, 8'($urandom), t, h, RESPONSE_BYTES, 10);
            end
            else
            begin
                send_response(sid, FUNC_READ, BYTE_COUNT, t, h, $urandom_range(0, 8), 10);
                if (pick < 94 && timeout_ticks <= 64)
                begin
                    while (awaiting)
                    begin
                        send_tick();
                    end
                end
            end
        end
    endtask

    task automatic test_backpressure();
        logic [7:0] sid;
        set_idling(0, 0);
        hold_left = 300;
        repeat (5)
        begin
            sid = 8'($urandom);
            send_start(sid, 16'($urandom));
            send_response(sid, FUNC_READ, BYTE_COUNT, 16'($urandom), 16'($urandom),
                          RESPONSE_BYTES, 0);
        end
        wait_drained();
        set_idling(0, 50);
        hold_left = 120;
        repeat (3) random_exchange();
        wait_drained();
    endtask

    task automatic test_random();
        int          src_mix  [4] = '{0, 73, 0, 30};
        int          sink_mix [4] = '{0, 0, 73, 30};
        logic [15:0] limits   [4] = '{16'd6, 16'd1, 16'd12, 16'hFFFF};
        int          first;
        for (int p = 0; p < 4; p++)
        begin
            write_cfg(CFG_LINK_ENABLED, 16'h0000);
            set_idling(src_mix[p], sink_mix[p]);
            repeat (2) send_start(8'($urandom), 16'($urandom));
            wait_drained();
            write_cfg(CFG_LINK_ENABLED, 16'h0001);
            write_cfg(CFG_RESPONSE_TIMEOUT, limits[p]);
            first = items_sent;
            while (items_sent - first < PHASE_ITEMS)
            begin
                random_exchange();
            end
            wait_drained();
        end
        set_idling(0, 0);
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge clk)
    begin
        result_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            got.kind               = kind_t'(result_ch.kind);
            got.tx_byte            = result_ch.tx_byte;
            got.last               = result_ch.last;
            got.status             = status_t'(result_ch.status);
            got.exception_code     = result_ch.exception_code;
            got.temperature_tenths = result_ch.temperature_tenths;
            got.humidity_tenths    = result_ch.humidity_tenths;
            results_seen++;
            if (got.kind == KIND_REPORT)
            begin
                status_count[got.status]++;
            end
            if (results_due.size() == 0)
            begin
                errors++;
                if (errors <= SHOW_LIMIT)
                begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, got);
                end
            end
            else
            begin
                want = results_due.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= SHOW_LIMIT)
                    begin
                        $display("%0t: result mismatch, expected %p, actual %p",
                                 $time, want, got);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: cycle limit reached with %0d results outstanding",
                     $time, results_due.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_LINK_ENABLED;
        cfg_data          = '0;
        item_ch.valid     = 1'b0;
        item_ch.command   = CMD_START;
        item_ch.target_id = '0;
        item_ch.reg_addr  = '0;
        item_ch.rx_byte   = '0;
        result_ch.ready   = 1'b0;
        link_on           = 1'b0;
        timeout_ticks     = TIMEOUT_RESET;
        awaiting          = 1'b0;
        want_slave        = '0;
        rx_count          = '0;
        ticks_seen        = '0;
        foreach (rx_store[i])
        begin
            rx_store[i] = '0;
        end
        foreach (status_count[i])
        begin
            status_count[i] = 0;
        end
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_link_down();
        test_good_reads();
        test_bad_responses();
        test_restart_and_abort();
        test_timeouts();
        test_backpressure();
        test_random();

        wait_drained();
        $display("Run covered %0d transfers in, %0d results out, four idle/stall mixes,",
                 items_sent, results_seen);
        $display("  %0d errors; reports: ok %0d, timeout %0d, slave %0d, exception %0d,",
                 errors, status_count[ST_OK], status_count[ST_TIMEOUT],
                 status_count[ST_SLAVE_MISMATCH], status_count[ST_EXCEPTION]);
        $display("  function %0d, count %0d, link down %0d",
                 status_count[ST_UNKNOWN_FUNC], status_count[ST_BAD_COUNT],
                 status_count[ST_NOT_CONNECTED]);
        if (errors == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
